// ===== rtl/core/ufc_pkg.sv =====
package ufc_pkg;

  // Default geometry of the concealer.
  localparam int FADE_FRAMES_DEF = 96;
  localparam int SAMPLE_BITS_DEF = 24;

  // Gains are Q1.16: unity is 65536 and needs seventeen bits.
  localparam int GAIN_FRAC = 16;
  localparam int GAIN_W    = GAIN_FRAC + 1;
  localparam logic [GAIN_W-1:0] GAIN_ONE  = GAIN_W'(65536);
  localparam logic [GAIN_W-1:0] GAIN_ZERO = '0;

  // Pi in Q30, used to build the fade curve at elaboration.
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

endpackage

// ===== rtl/core/ufc_in_if.sv =====
interface ufc_in_if #(
  parameter int SAMPLE_BITS = ufc_pkg::SAMPLE_BITS_DEF
);

  logic                          valid;
  logic                          ready;
  logic                          sample_valid;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;

  modport source (output valid, output sample_valid, output left_in, output right_in,
                  input ready);
  modport sink (input valid, input sample_valid, input left_in, input right_in,
                output ready);

endinterface

// ===== rtl/core/ufc_out_if.sv =====
interface ufc_out_if #(
  parameter int SAMPLE_BITS = ufc_pkg::SAMPLE_BITS_DEF
);

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink (input valid, input left_out, input right_out, output ready);

endinterface

// ===== rtl/core/ufc_gain_mul.sv =====
module ufc_gain_mul #(
  parameter int SAMPLE_BITS = ufc_pkg::SAMPLE_BITS_DEF
) (
  input  logic signed [SAMPLE_BITS-1:0]      sample_i,
  input  logic        [ufc_pkg::GAIN_W-1:0]  gain_i,
  output logic signed [SAMPLE_BITS-1:0]      scaled_o
);

  localparam int PROD_W = SAMPLE_BITS + ufc_pkg::GAIN_W + 1;

  logic signed [PROD_W-1:0]          prod;
  logic signed [ufc_pkg::GAIN_W:0]   gain_s;

  // Gain is unsigned, so it gets a zero sign bit before the signed multiply.
  assign gain_s = $signed({1'b0, gain_i});
  assign prod   = PROD_W'(sample_i) * PROD_W'(gain_s);

  // The arithmetic drop of the fraction bits rounds towards minus infinity.
  // A gain of at most one keeps the result inside the sample range.
  assign scaled_o = prod[SAMPLE_BITS+ufc_pkg::GAIN_FRAC-1:ufc_pkg::GAIN_FRAC];

endmodule

// ===== rtl/core/underrun_fade_concealer.sv =====
// Underrun fade concealer for a stereo stream, one frame per item.
// The input channel carries sample_valid with the left and right samples;
// sample_valid low marks a frame the buffer could not supply. The output
// channel carries one faded left/right pair for every input item, in order.
// A supplied frame after an underrun starts a raised-cosine fade-in over
// FADE_FRAMES frames; the first missing frame anchors the last output pair
// and fades it down to zero over FADE_FRAMES frames, where it stays.
// An accepted item is held in the gain-select register, then moves on to
// the result register, which drives the output channel.
// Throughput: one item per cycle while the receiver keeps up, since the gain
// register refills in the same cycle as it hands its item to the result.
// Reset clears the underrun and fade-in state, parks both fade indices at
// their end, and zeroes the anchor and held pairs, so an underrun straight
// after reset gives silence. When the receiver stalls, the result register
// holds its item, the gain register takes one more, and then ready drops.
module underrun_fade_concealer #(
  parameter int FADE_FRAMES = ufc_pkg::FADE_FRAMES_DEF,
  parameter int SAMPLE_BITS = ufc_pkg::SAMPLE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ufc_in_if.sink      in_i,
  ufc_out_if.source   out_o
);

  localparam int IDX_W     = $clog2(FADE_FRAMES + 1);
  localparam int ROM_AW    = (FADE_FRAMES > 1) ? $clog2(FADE_FRAMES) : 1;
  localparam int ANGLE_DIV = 2 * FADE_FRAMES;
  localparam logic [IDX_W-1:0] FADE_LAST = IDX_W'(FADE_FRAMES);

  // Curve point k in Q1.16: sine squared of the angle, by a Taylor series.
  function automatic logic [ufc_pkg::GAIN_W-1:0] fade_gain(input int k);
    logic        [63:0] x;
    logic        [63:0] x2;
    logic        [63:0] t;
    logic signed [63:0] s;
    logic        [63:0] g;
    x  = (ufc_pkg::PI_Q30 * 64'(k + 1)) / ANGLE_DIV;
    x2 = (x * x) >> 30;
    s  = $signed(x);
    t  = ((x * x2) >> 30) / 6;
    s  = s - $signed(t);
    t  = ((t * x2) >> 30) / 20;
    s  = s + $signed(t);
    t  = ((t * x2) >> 30) / 42;
    s  = s - $signed(t);
    t  = ((t * x2) >> 30) / 72;
    s  = s + $signed(t);
    t  = ((t * x2) >> 30) / 110;
    s  = s - $signed(t);
    t  = ((t * x2) >> 30) / 156;
    s  = s + $signed(t);
    t  = ((t * x2) >> 30) / 210;
    s  = s - $signed(t);
    if (s < 0) begin
      s = '0;
    end
    g = (64'(s) * 64'(s) + (64'd1 << 43)) >> 44;
    if (g > 64'(ufc_pkg::GAIN_ONE)) begin
      g = 64'(ufc_pkg::GAIN_ONE);
    end
    return g[ufc_pkg::GAIN_W-1:0];
  endfunction

  // Constant fade curve, one entry per frame of the fade.
  logic [ufc_pkg::GAIN_W-1:0] curve_rom [FADE_FRAMES];

  for (genvar g = 0; g < FADE_FRAMES; g++) begin : g_rom
    assign curve_rom[g] = fade_gain(g);
  end

  // Fade state, updated as each item is accepted.
  logic             underrun_q, underrun_d;
  logic             rec_active_q, rec_active_d;
  logic [IDX_W-1:0] rec_idx_q, rec_idx_d;
  logic [IDX_W-1:0] fade_idx_q, fade_idx_d;

  // Gain-select register.
  logic                          s1_vld_q;
  logic                          s1_frame_q;
  logic                          s1_start_q;
  logic [ufc_pkg::GAIN_W-1:0]    s1_gain_q;
  logic signed [SAMPLE_BITS-1:0] s1_left_q;
  logic signed [SAMPLE_BITS-1:0] s1_right_q;

  // Result register and the pairs kept for fade-out.
  logic                          out_vld_q;
  logic signed [SAMPLE_BITS-1:0] out_left_q;
  logic signed [SAMPLE_BITS-1:0] out_right_q;
  logic signed [SAMPLE_BITS-1:0] held_l_q;
  logic signed [SAMPLE_BITS-1:0] held_r_q;
  logic signed [SAMPLE_BITS-1:0] anchor_l_q;
  logic signed [SAMPLE_BITS-1:0] anchor_r_q;

  logic                          in_acc;
  logic                          out_load;
  logic                          start_fade;
  logic [IDX_W-1:0]              idx_sel;
  logic [IDX_W-1:0]              lut_idx;
  logic [ufc_pkg::GAIN_W-1:0]    curve_val;
  logic [ufc_pkg::GAIN_W-1:0]    gain_d;
  logic signed [SAMPLE_BITS-1:0] op_l;
  logic signed [SAMPLE_BITS-1:0] op_r;
  logic signed [SAMPLE_BITS-1:0] res_l;
  logic signed [SAMPLE_BITS-1:0] res_r;

  // Handshake: the gain register moves on whenever the result register frees.
  assign out_load   = s1_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !s1_vld_q || out_load;
  assign in_acc     = in_i.valid && in_i.ready;

  // Index of the curve entry this item would use, before the range check.
  always_comb begin
    start_fade = !underrun_q;
    if (in_i.sample_valid) begin
      idx_sel = underrun_q ? '0 : rec_idx_q;
    end else begin
      idx_sel = start_fade ? '0 : fade_idx_q;
    end
  end

  assign lut_idx   = idx_sel;
  assign curve_val = curve_rom[lut_idx[ROM_AW-1:0]];

  // Next fade state and the gain for this item.
  always_comb begin
    underrun_d   = underrun_q;
    rec_active_d = rec_active_q;
    rec_idx_d    = rec_idx_q;
    fade_idx_d   = fade_idx_q;
    gain_d       = ufc_pkg::GAIN_ONE;
    if (in_i.sample_valid) begin
      underrun_d   = 1'b0;
      rec_active_d = underrun_q || rec_active_q;
      rec_idx_d    = idx_sel;
      if (underrun_q || rec_active_q) begin
        if (idx_sel < FADE_LAST) begin
          gain_d    = curve_val;
          rec_idx_d = idx_sel + IDX_W'(1);
        end else begin
          rec_active_d = 1'b0;
        end
      end
    end else begin
      underrun_d   = 1'b1;
      rec_active_d = 1'b0;
      fade_idx_d   = idx_sel;
      if (idx_sel < FADE_LAST) begin
        gain_d     = ufc_pkg::GAIN_ONE - curve_val;
        fade_idx_d = idx_sel + IDX_W'(1);
      end else begin
        gain_d = ufc_pkg::GAIN_ZERO;
      end
    end
  end

  // Fade state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      underrun_q   <= 1'b0;
      rec_active_q <= 1'b0;
      rec_idx_q    <= FADE_LAST;
      fade_idx_q   <= FADE_LAST;
    end else if (in_acc) begin
      underrun_q   <= underrun_d;
      rec_active_q <= rec_active_d;
      rec_idx_q    <= rec_idx_d;
      fade_idx_q   <= fade_idx_d;
    end
  end

  // Gain-select register: control part.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_acc) begin
      s1_vld_q <= 1'b1;
    end else if (out_load) begin
      s1_vld_q <= 1'b0;
    end
  end

  // Gain-select register: payload part.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_frame_q <= in_i.sample_valid;
      s1_start_q <= start_fade;
      s1_gain_q  <= gain_d;
      s1_left_q  <= in_i.left_in;
      s1_right_q <= in_i.right_in;
    end
  end

  // A missing frame scales the anchor; the first one takes the held pair.
  always_comb begin
    if (s1_frame_q) begin
      op_l = s1_left_q;
      op_r = s1_right_q;
    end else if (s1_start_q) begin
      op_l = held_l_q;
      op_r = held_r_q;
    end else begin
      op_l = anchor_l_q;
      op_r = anchor_r_q;
    end
  end

  ufc_gain_mul #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mul_l (
    .sample_i (op_l),
    .gain_i   (s1_gain_q),
    .scaled_o (res_l)
  );

  ufc_gain_mul #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mul_r (
    .sample_i (op_r),
    .gain_i   (s1_gain_q),
    .scaled_o (res_r)
  );

  // Held and anchor pairs follow the items leaving the gain register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_l_q   <= '0;
      held_r_q   <= '0;
      anchor_l_q <= '0;
      anchor_r_q <= '0;
    end else if (out_load) begin
      if (s1_frame_q) begin
        held_l_q <= res_l;
        held_r_q <= res_r;
      end else if (s1_start_q) begin
        anchor_l_q <= held_l_q;
        anchor_r_q <= held_r_q;
      end
    end
  end

  // Result register: control part.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  // Result register: payload part.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_left_q  <= res_l;
      out_right_q <= res_r;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.left_out  = out_left_q;
  assign out_o.right_out = out_right_q;

  // Once the fade-out has run its course, further missing frames are silent.
  a_fade_floor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !in_i.sample_valid && underrun_q && (fade_idx_q == FADE_LAST)
    |=> (s1_gain_q == ufc_pkg::GAIN_ZERO))
    else $error("gain not zero after a completed fade-out");

  // A fade-in cannot be running during an underrun.
  a_rec_vs_underrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_active_q |-> !underrun_q)
    else $error("fade-in active while in underrun");

  // Both fade indices stay within the curve length.
  a_idx_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rec_idx_q <= FADE_LAST) && (fade_idx_q <= FADE_LAST))
    else $error("fade index beyond curve length");

  // A supplied frame leaves its output pair in the held registers.
  a_held_tracks_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && s1_frame_q
    |=> (held_l_q == out_o.left_out) && (held_r_q == out_o.right_out))
    else $error("held pair differs from last supplied output");

endmodule

// ===== test/ufc_fade_checker.sv =====
// Watches both channels of the underrun fade concealer, predicts every
// output pair from the accepted input items and compares them in order.
module ufc_fade_checker #(
  parameter int FADE_FRAMES = ufc_pkg::FADE_FRAMES_DEF,
  parameter int SAMPLE_BITS = ufc_pkg::SAMPLE_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  ufc_in_if    in_mon,
  ufc_out_if   out_mon,
  output int   fail_count_o,
  output int   pending_o
);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [ufc_pkg::GAIN_W-1:0]    gain_t;

  typedef struct packed {
    sample_t left;
    sample_t right;
  } stereo_pair_t;

  // Fade curve in Q1.16, one entry per fade step.
  gain_t fade_gain [FADE_FRAMES];

  // Shadow copy of the concealer state.
  logic        in_underrun;
  logic        fade_in_active;
  int unsigned fade_in_step;
  int unsigned fade_out_step;
  sample_t     anchor_l;
  sample_t     anchor_r;
  sample_t     last_l;
  sample_t     last_r;

  stereo_pair_t expected_pairs [$];

  // Raised-cosine gain for step k: sine by Taylor series in Q30, then squared.
  function automatic gain_t raised_cosine_gain(int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint          s;
    longint          g;
    x  = (ufc_pkg::PI_Q30 * 64'(k + 1)) / 64'(2 * FADE_FRAMES);
    x2 = (x * x) >> 30;
    s  = longint'(x);
    t  = x;
    for (int unsigned n = 1; n <= 7; n++) begin
      t = ((t * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        s = s - longint'(t);
      end else begin
        s = s + longint'(t);
      end
    end
    if (s < 0) begin
      s = 0;
    end
    g = (s * s + (longint'(1) <<< 43)) >>> 44;
    if (g > longint'(ufc_pkg::GAIN_ONE)) begin
      g = longint'(ufc_pkg::GAIN_ONE);
    end
    return gain_t'(g);
  endfunction

  // Gain applied with truncation toward minus infinity.
  function automatic sample_t scale_sample(longint sample, longint gain);
    longint product;
    product = sample * gain;
    return sample_t'(product >>> ufc_pkg::GAIN_FRAC);
  endfunction

  // Works out the output pair of one frame and advances the shadow state.
  function automatic stereo_pair_t conceal_frame(logic supplied, sample_t l_in,
                                                 sample_t r_in);
    stereo_pair_t pair;
    longint       gain;
    if (supplied) begin
      gain = longint'(ufc_pkg::GAIN_ONE);
      if (in_underrun) begin
        fade_in_active = 1'b1;
        fade_in_step   = 0;
      end
      if (fade_in_active) begin
        if (fade_in_step < FADE_FRAMES) begin
          gain = longint'(fade_gain[fade_in_step]);
          fade_in_step++;
        end else begin
          fade_in_active = 1'b0;
        end
      end
      pair.left   = scale_sample(longint'(l_in), gain);
      pair.right  = scale_sample(longint'(r_in), gain);
      last_l      = pair.left;
      last_r      = pair.right;
      in_underrun = 1'b0;
    end else begin
      // The first missing frame takes the last output pair as its anchor.
      if (!in_underrun) begin
        anchor_l      = last_l;
        anchor_r      = last_r;
        fade_out_step = 0;
      end
      fade_in_active = 1'b0;
      if (fade_out_step < FADE_FRAMES) begin
        gain = longint'(ufc_pkg::GAIN_ONE) - longint'(fade_gain[fade_out_step]);
        fade_out_step++;
      end else begin
        gain = longint'(ufc_pkg::GAIN_ZERO);
      end
      pair.left   = scale_sample(longint'(anchor_l), gain);
      pair.right  = scale_sample(longint'(anchor_r), gain);
      in_underrun = 1'b1;
    end
    return pair;
  endfunction

  // The curve is fixed, so it is built once at the start.
  initial begin
    for (int unsigned k = 0; k < FADE_FRAMES; k++) begin
      fade_gain[k] = raised_cosine_gain(k);
    end
  end

  // Predict on every accepted input item and compare every accepted result.
  always @(posedge clk_i or negedge rst_ni) begin
    stereo_pair_t want;
    int           errors;
    errors = 0;
    if (!rst_ni) begin
      in_underrun    <= 1'b0;
      fade_in_active <= 1'b0;
      fade_in_step   <= FADE_FRAMES;
      fade_out_step  <= FADE_FRAMES;
      anchor_l       <= '0;
      anchor_r       <= '0;
      last_l         <= '0;
      last_r         <= '0;
      expected_pairs.delete();
      fail_count_o   <= 0;
      pending_o      <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        expected_pairs.push_back(conceal_frame(in_mon.sample_valid, in_mon.left_in,
                                               in_mon.right_in));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_pairs.size() == 0) begin
          $error("unexpected output item: left_out %0d right_out %0d",
                 out_mon.left_out, out_mon.right_out);
          errors++;
        end else begin
          want = expected_pairs.pop_front();
          if (out_mon.left_out !== want.left) begin
            $error("left_out: expected %0d, actual %0d", want.left, out_mon.left_out);
            errors++;
          end
          if (out_mon.right_out !== want.right) begin
            $error("right_out: expected %0d, actual %0d", want.right, out_mon.right_out);
            errors++;
          end
        end
      end
      fail_count_o <= fail_count_o + errors;
      pending_o    <= expected_pairs.size();
    end
  end

endmodule

// ===== test/tb_underrun_fade_concealer.sv =====
// Stimulus and verdict for the underrun fade concealer.
module tb_underrun_fade_concealer;

  localparam int FADE_FRAMES = ufc_pkg::FADE_FRAMES_DEF;
  localparam int SAMPLE_BITS = ufc_pkg::SAMPLE_BITS_DEF;
  localparam int ITEMS_PER_PHASE = 250;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_NEG1 = '1;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_ONE = SAMPLE_BITS'(1);

  logic clk_i = 1'b0;
  logic rst_ni;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   fail_count;
  int   pending;

  ufc_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
  ufc_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_ch ();

  underrun_fade_concealer #(
    .FADE_FRAMES(FADE_FRAMES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  ufc_fade_checker #(
    .FADE_FRAMES(FADE_FRAMES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Clock with a period of ten.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The receiver stalls at random, at the rate of the current phase.
  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Offers one frame, after random gaps, and waits until it is taken.
  task automatic send_frame(logic supplied, logic [SAMPLE_BITS-1:0] l,
                            logic [SAMPLE_BITS-1:0] r);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.sample_valid <= supplied;
    in_ch.left_in      <= l;
    in_ch.right_in     <= r;
    do begin
      @(posedge clk_i);
    end while (!in_ch.ready);
  endtask

  // Random full-range samples half the time; the extremes, minus one and zero otherwise.
  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(0, 7))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return SAMPLE_NEG1;
      3: return '0;
      default: return raw[SAMPLE_BITS-1:0];
    endcase
  endfunction

  // Runs of supplied and missing frames, some long enough to finish a fade,
  // with short bursts of mixed frames as noise.
  task automatic send_random_frames(int count);
    int sent;
    int run_len;
    int kind;
    logic supplied;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 85) begin
        run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(FADE_FRAMES + 1, FADE_FRAMES + 40)
                                              : $urandom_range(1, 20);
      end else begin
        run_len = $urandom_range(1, 6);
      end
      if (run_len > count - sent) begin
        run_len = count - sent;
      end
      for (int i = 0; i < run_len; i++) begin
        if (kind < 45) begin
          supplied = 1'b1;
        end else if (kind < 85) begin
          supplied = 1'b0;
        end else begin
          supplied = 1'($urandom_range(0, 1));
        end
        send_frame(supplied, pick_sample(), pick_sample());
      end
      sent += run_len;
    end
  endtask

  // Reset, directed frames, three random phases, drain and verdict.
  initial begin
    rst_ni             = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.sample_valid = 1'b0;
    in_ch.left_in      = '0;
    in_ch.right_in     = '0;
    send_idle_pct      = 13;
    recv_idle_pct      = 87;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // An underrun straight after reset must give silence.
    send_frame(1'b0, SAMPLE_MAX, SAMPLE_MIN);
    send_frame(1'b0, SAMPLE_NEG1, SAMPLE_NEG1);
    // Recovery starts a fade-in on the extremes.
    send_frame(1'b1, SAMPLE_MAX, SAMPLE_MIN);
    send_frame(1'b1, SAMPLE_MIN, SAMPLE_MAX);
    send_frame(1'b1, SAMPLE_NEG1, SAMPLE_ONE);
    send_frame(1'b1, '0, '0);
    send_frame(1'b1, SAMPLE_MAX, SAMPLE_MIN);
    // A missing frame anchors the last output pair and fades it out;
    // the samples offered with it are ignored.
    send_frame(1'b0, '0, '0);
    send_frame(1'b0, SAMPLE_MAX, SAMPLE_MAX);
    send_frame(1'b0, SAMPLE_NEG1, SAMPLE_MIN);
    // A fade-in cut short by a new underrun.
    send_frame(1'b1, SAMPLE_MIN, SAMPLE_MIN);
    send_frame(1'b1, SAMPLE_MAX, SAMPLE_MAX);
    send_frame(1'b0, '0, SAMPLE_NEG1);
    send_frame(1'b1, SAMPLE_ONE, SAMPLE_NEG1);
    send_frame(1'b0, SAMPLE_MIN, '0);
    send_frame(1'b0, '0, SAMPLE_MAX);
    send_frame(1'b1, SAMPLE_NEG1, SAMPLE_MAX);
    send_frame(1'b1, SAMPLE_MIN, SAMPLE_ONE);

    send_random_frames(ITEMS_PER_PHASE);
    send_idle_pct = 87;
    recv_idle_pct = 13;
    send_random_frames(ITEMS_PER_PHASE);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_frames(ITEMS_PER_PHASE);

    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending != 0) begin
      @(negedge clk_i);
    end
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== underrun_fade_concealer.f =====
rtl/core/ufc_pkg.sv
rtl/core/ufc_in_if.sv
rtl/core/ufc_out_if.sv
rtl/core/ufc_gain_mul.sv
rtl/core/underrun_fade_concealer.sv
test/ufc_fade_checker.sv
test/tb_underrun_fade_concealer.sv
